// ----- rtl/pointer_pair_hash_table_macros.svh -----
// Assertion helpers for the pair-keyed hash table.
`ifndef POINTER_PAIR_HASH_TABLE_MACROS_SVH
`define POINTER_PAIR_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define PPH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pph assertion failed");
`define PPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pph assertion failed");
`else
`define PPH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PPH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/pph_pkg.sv -----
package pph_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_SHIFT = 3;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 64;
	localparam int LIMIT_W   = 7;
	localparam int STAT_W    = 3;

	localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = LIMIT_W'(48);

	localparam logic OP_SET    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_KEY   = 3'd5;

	localparam logic [1:0] REG_LOAD_LIMIT = 2'd0;

	typedef struct packed {
		logic [KEY_W-1:0] key_first;
		logic [KEY_W-1:0] key_second;
		logic [VAL_W-1:0] value;
	} slot_t;

	// low bits of (k1 >> KEY_SHIFT) ^ (k2 >> KEY_SHIFT); capacity is a power of two
	function automatic logic [IDX_W-1:0] pair_slot(input logic [KEY_W-1:0] k1,
			input logic [KEY_W-1:0] k2);
		pair_slot = k1[KEY_SHIFT +: IDX_W] ^ k2[KEY_SHIFT +: IDX_W];
	endfunction

endpackage

// ----- rtl/pph_slot_ram.sv -----
module pph_slot_ram
	import pph_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  slot_t            wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output slot_t            rd_data
);

	slot_t mem [CAPACITY];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/pointer_pair_hash_table.sv -----
// Pair-keyed hash table, open addressing with linear probing, 64 slots.
// Command channel: start with op, key_first, key_second, value_in is taken
// when start is high and busy is low. op set writes the pair's value, op lookup
// reads it. A zero key_first answers bad key in the next cycle.
// Result channel: done is high for one cycle with status, value_out and
// entries_used; the receiver cannot stall, so the result is lost if not taken.
// Probing: P slots are probed (1 to 64) between acceptance and done. The slot
// RAM has one registered read port; one slot is read and compared per cycle,
// the next address issued while the current one is compared. busy is high
// during probing and a new transaction can be accepted in the cycle in which
// done is shown.
// Configuration: APB register load_limit at address 0, reset value 48, to be
// written only while idle. pready is always high.
// Reset: all slots read as empty and the entry count is zero at once; slot
// contents are not cleared.
`include "pointer_pair_hash_table_macros.svh"

module pointer_pair_hash_table
	import pph_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [KEY_W-1:0]   key_first,
	input  logic [KEY_W-1:0]   key_second,
	input  logic [VAL_W-1:0]   value_in,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [VAL_W-1:0]   value_out,
	output logic [CNT_W-1:0]   entries_used,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_PROBE = 1'b1;

	logic                state_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    occ_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [VAL_W-1:0]    value_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    probe_cnt_q;
	logic                op_q;
	logic [KEY_W-1:0]    kf_q;
	logic [KEY_W-1:0]    ks_q;
	logic [VAL_W-1:0]    vin_q;

	logic                accept;
	logic                bad_key;
	logic                cfg_wr;
	logic [IDX_W-1:0]    rd_addr;
	slot_t               rd_slot;
	slot_t               wr_slot;
	logic                slot_empty;
	logic                slot_hit;
	logic                is_full;
	logic                finish;
	logic                do_write;
	logic                do_insert;
	logic [STAT_W-1:0]   res_status;
	logic [VAL_W-1:0]    res_value;

	assign busy    = (state_q == S_PROBE);
	assign accept  = start && !busy;
	assign bad_key = (key_first == '0);
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr == REG_LOAD_LIMIT);
	assign pready  = 1'b1;
	assign prdata  = (paddr == REG_LOAD_LIMIT) ? {{(32 - LIMIT_W){1'b0}}, limit_q} : '0;

	assign rd_addr = busy ? idx_q + 1'b1 : pair_slot(key_first, key_second);

	assign wr_slot.key_first  = kf_q;
	assign wr_slot.key_second = ks_q;
	assign wr_slot.value      = vin_q;

	pph_slot_ram u_ram (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (idx_q),
		.wr_data (wr_slot),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	always_comb begin
		slot_empty = !valid_q[idx_q];
		slot_hit   = valid_q[idx_q] && (rd_slot.key_first == kf_q) &&
			(rd_slot.key_second == ks_q);
		is_full    = (CNT_W'(limit_q) <= occ_q) ||
			(occ_q >= CNT_W'(CAPACITY));
		finish     = 1'b0;
		do_write   = 1'b0;
		do_insert  = 1'b0;
		res_status = ST_NOT_FOUND;
		res_value  = '0;
		if (busy) begin
			if (slot_empty) begin
				finish = 1'b1;
				if (op_q == OP_LOOKUP) begin
					res_status = ST_NOT_FOUND;
				end else if (is_full) begin
					res_status = ST_FULL;
				end else begin
					do_write   = 1'b1;
					do_insert  = 1'b1;
					res_status = ST_INSERTED;
				end
			end else if (slot_hit) begin
				finish = 1'b1;
				if (op_q == OP_LOOKUP) begin
					res_status = ST_FOUND;
					res_value  = rd_slot.value;
				end else begin
					do_write   = 1'b1;
					res_status = ST_UPDATED;
				end
			end else if (probe_cnt_q == IDX_W'(CAPACITY - 1)) begin
				finish     = 1'b1;
				res_status = (op_q == OP_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			occ_q   <= '0;
			limit_q <= LOAD_LIMIT_RESET;
			done_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					done_q <= accept && bad_key;
					if (accept && !bad_key) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					done_q <= finish;
					if (finish) begin
						state_q <= S_IDLE;
					end
					if (do_insert) begin
						valid_q[idx_q] <= 1'b1;
						occ_q          <= occ_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op;
			kf_q        <= key_first;
			ks_q        <= key_second;
			vin_q       <= value_in;
			idx_q       <= pair_slot(key_first, key_second);
			probe_cnt_q <= '0;
			status_q    <= ST_BAD_KEY;
			value_q     <= '0;
		end else if (busy) begin
			if (finish) begin
				status_q <= res_status;
				value_q  <= res_value;
			end else begin
				idx_q       <= idx_q + 1'b1;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign value_out    = value_q;
	assign entries_used = occ_q;

	`PPH_ASSERT_IMPLIES(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CNT_W'(CAPACITY))
	`PPH_ASSERT_IMPLIES(a_done_idle, clk, arst_n, done_q, !busy)
	`PPH_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, done_q || busy)
	`PPH_ASSERT_IMPLIES(a_insert_count, clk, arst_n, done_q && (status_q == ST_INSERTED), occ_q == CNT_W'($past(occ_q) + 1'b1))

endmodule

// ----- tb/sv/pointer_pair_hash_table_tb.sv -----
module pointer_pair_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pph_pkg::*;

	localparam int POOL_SIZE      = 96;
	localparam int PHASE_ITEMS    = 135;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 70;
	localparam logic [KEY_W-1:0] ONES = '1;
	localparam logic [KEY_W-1:0] MSB  = {1'b1, {(KEY_W-1){1'b0}}};

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] k1;
		logic [KEY_W-1:0] k2;
		logic [VAL_W-1:0] v;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
		logic [CNT_W-1:0]  used;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_SET;
	logic [KEY_W-1:0]   key_first = '0;
	logic [KEY_W-1:0]   key_second = '0;
	logic [VAL_W-1:0]   value_in = '0;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [VAL_W-1:0]   value_out;
	logic [CNT_W-1:0]   entries_used;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	pointer_pair_hash_table uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.key_first(key_first), .key_second(key_second), .value_in(value_in),
		.done(done), .status(status), .value_out(value_out), .entries_used(entries_used),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the slot store
	bit               tbl_valid [CAPACITY];
	logic [KEY_W-1:0] tbl_k1 [CAPACITY];
	logic [KEY_W-1:0] tbl_k2 [CAPACITY];
	logic [VAL_W-1:0] tbl_val [CAPACITY];
	int               tbl_count = 0;
	int               cfg_limit = int'(LOAD_LIMIT_RESET);

	logic [KEY_W-1:0] pool_k1 [POOL_SIZE];
	logic [KEY_W-1:0] pool_k2 [POOL_SIZE];

	cmd_t   pending_cmds[$];
	reply_t expected_replies[$];
	cmd_t   cur_cmd;
	bit     cmd_taken = 1'b0;
	bit     gapless = 1'b0;
	int     gap_left = 0;
	int     n_queued = 0;
	int     n_replied = 0;
	int     mismatches = 0;
	int     idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gapless || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic reply_t table_access(cmd_t c);
		reply_t      r;
		logic [31:0] h;
		int          idx;
		int          slot;
		bit          hit;
		r.status = ST_BAD_KEY;
		r.value = '0;
		if (c.k1 != '0) begin
			h = 32'(c.k1 >> KEY_SHIFT) ^ 32'(c.k2 >> KEY_SHIFT);
			idx = int'(h % 32'(CAPACITY));
			slot = -1;
			hit = 1'b0;
			for (int n = 0; n < CAPACITY && slot < 0; n++) begin
				if (!tbl_valid[idx]) begin
					slot = idx;
				end else if (tbl_k1[idx] == c.k1 && tbl_k2[idx] == c.k2) begin
					slot = idx;
					hit = 1'b1;
				end else begin
					idx = (idx + 1) % CAPACITY;
				end
			end
			if (c.op == OP_LOOKUP) begin
				if (hit) begin
					r.status = ST_FOUND;
					r.value = tbl_val[slot];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end else if (hit) begin
				tbl_val[slot] = c.v;
				r.status = ST_UPDATED;
			end else if (slot < 0 || tbl_count + 1 > cfg_limit || tbl_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				tbl_valid[slot] = 1'b1;
				tbl_k1[slot] = c.k1;
				tbl_k2[slot] = c.k2;
				tbl_val[slot] = c.v;
				tbl_count++;
				r.status = ST_INSERTED;
			end
		end
		r.used = CNT_W'(tbl_count);
		return r;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		int   p;
		r = $urandom_range(0, 99);
		c.op = $urandom_range(0, 1) ? OP_LOOKUP : OP_SET;
		if (r < 5) begin
			c.k1 = '0;
			c.k2 = rand64();
		end else if (r < 15) begin
			c.k1 = rand64() | 64'd1;
			c.k2 = rand64();
		end else begin
			p = $urandom_range(0, POOL_SIZE - 1);
			c.k1 = pool_k1[p];
			c.k2 = pool_k2[p];
		end
		r = $urandom_range(0, 9);
		c.v = (r == 0) ? '0 : (r == 1) ? ONES : rand64();
		return c;
	endfunction

	task automatic push_cmd(input logic o, input logic [KEY_W-1:0] k1,
			input logic [KEY_W-1:0] k2, input logic [VAL_W-1:0] v);
		pending_cmds.push_back('{op: o, k1: k1, k2: k2, v: v});
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_replied != n_queued)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_load_limit(input logic [LIMIT_W-1:0] lim);
		logic [31-LIMIT_W:0] upper;
		upper = $urandom_range(0, 1) ? (32 - LIMIT_W)'($urandom) : '0;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'(4 * int'(REG_LOAD_LIMIT));
		pwdata <= {upper, lim};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_limit = int'(lim);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && !(start && !cmd_taken)) begin
			cmd_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cur_cmd = pending_cmds.pop_front();
				op <= cur_cmd.op;
				key_first <= cur_cmd.k1;
				key_second <= cur_cmd.k2;
				value_in <= cur_cmd.v;
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected transaction, status %0d value %h used %0d",
						$time, status, value_out, entries_used);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					n_replied++;
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						mismatches++;
					end
					if (value_out !== want.value) begin
						$display("%0t: value_out expected %h actual %h",
							$time, want.value, value_out);
						mismatches++;
					end
					if (entries_used !== want.used) begin
						$display("%0t: entries_used expected %0d actual %0d",
							$time, want.used, entries_used);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				expected_replies.push_back(table_access('{op: op, k1: key_first,
					k2: key_second, v: value_in}));
				cmd_taken = 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [LIMIT_W-1:0] phase_limits [6];
		phase_limits = '{7'd16, 7'd40, 7'd1, 7'd64, 7'd127, 7'd0};
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_k2[i] = rand64();
			pool_k1[i] = (i > 0 && $urandom_range(0, 4) == 0) ? pool_k1[i-1] : rand64();
			// crowd part of the pool onto the last slots so probes wrap
			if ($urandom_range(0, 1))
				pool_k1[i][KEY_SHIFT +: IDX_W] = pool_k2[i][KEY_SHIFT +: IDX_W] ^
					IDX_W'($urandom_range(CAPACITY - 4, CAPACITY - 1));
			if (pool_k1[i] == '0)
				pool_k1[i] = MSB;
		end
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		push_cmd(OP_LOOKUP, '0, ONES, '0);
		push_cmd(OP_SET, '0, '0, ONES);
		push_cmd(OP_LOOKUP, 64'd1, '0, '0);
		push_cmd(OP_SET, 64'd1, '0, ONES);
		push_cmd(OP_SET, ONES, ONES, '0);
		push_cmd(OP_LOOKUP, 64'd1, '0, ONES);
		push_cmd(OP_LOOKUP, ONES, ONES, '0);
		push_cmd(OP_SET, 64'd1, '0, 64'h0123_4567_89ab_cdef);
		push_cmd(OP_LOOKUP, ONES, '0, '0);
		push_cmd(OP_SET, 64'h1f8, '0, MSB);
		push_cmd(OP_SET, 64'h1f8, 64'd1, rand64());
		push_cmd(OP_SET, 64'h1f8, MSB, rand64());
		push_cmd(OP_SET, 64'h1f8 | (64'd1 << 40), '0, rand64());
		push_cmd(OP_LOOKUP, 64'h1f8, MSB, '0);
		push_cmd(OP_LOOKUP, 64'h1f8, 64'd2, '0);
		push_cmd(OP_LOOKUP, MSB, '0, '0);
		wait_idle();

		set_load_limit(7'd0);
		push_cmd(OP_SET, 64'd1, '0, 64'hfeed_0000_0000_beef);
		push_cmd(OP_SET, 64'd2, 64'd3, rand64());
		push_cmd(OP_LOOKUP, 64'd1, '0, '0);
		wait_idle();

		set_load_limit(7'd1);
		push_cmd(OP_SET, 64'd4, 64'd5, rand64());
		push_cmd(OP_SET, ONES, ONES, 64'd5);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			set_load_limit(phase_limits[p]);
			gapless = (p % 3 == 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_cmds.push_back(random_cmd());
			n_queued += PHASE_ITEMS;
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_replies.size() != 0) begin
			$display("%0t: %0d transactions never arrived", $time, expected_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
